/* rtl/dsc_pkg.sv */
// ----------------------------------------------------------------------------
// Doppler shift color package
// Shared widths, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dsc_pkg;

  parameter int VEL_W    = 16;
  parameter int OBS_V_W  = 13;
  parameter int OBS_Z_W  = 20;
  parameter int COLOR_W  = 13;
  parameter int FACTOR_W = 16;
  parameter int DOT_W    = 40;
  parameter int MAG_W    = 39;
  parameter int RAD_W    = 42;
  parameter int LEN_W    = 21;
  parameter int BETA_QW  = 12;
  parameter int RATIO_NW = 37;
  parameter int RATIO_QW = 32;
  parameter int CFG_IDX_W  = 2;
  parameter int CFG_DATA_W = 20;

  parameter logic [CFG_IDX_W-1:0] REG_OBS_VEL = 2'd0;
  parameter logic [CFG_IDX_W-1:0] REG_OBS_Z   = 2'd1;

  parameter logic signed [OBS_V_W-1:0] OBS_VEL_RESET = 13'sd0;
  parameter logic [OBS_Z_W-1:0]        OBS_Z_RESET   = 20'd81920;

  parameter int ONE_Q12    = 4096;
  parameter int BETA_LIMIT = 4055;

  parameter int SEG_VIOLET = 1024;
  parameter int SEG_BLUE   = 1638;
  parameter int SEG_CYAN   = 2252;
  parameter int SEG_GREEN  = 2457;
  parameter int SEG_YELLOW = 3072;

  parameter int RECIP3      = 43691;
  parameter int RECIP3_SHFT = 17;

  typedef enum logic [1:0] {
    QSEL_NONE,
    QSEL_GREEN,
    QSEL_BLUE
  } qsel_t;

endpackage

`default_nettype wire

/* rtl/dsc_star_if.sv */
// ----------------------------------------------------------------------------
// Star velocity channel
// Valid/ready channel carrying one star velocity word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsc_star_if;
  logic                                valid;
  logic                                ready;
  logic signed [dsc_pkg::VEL_W-1:0]    velocity_x;
  logic signed [dsc_pkg::VEL_W-1:0]    velocity_y;
  logic signed [dsc_pkg::VEL_W-1:0]    velocity_z;

  modport source(output valid, velocity_x, velocity_y, velocity_z, input ready);
  modport sink(input valid, velocity_x, velocity_y, velocity_z, output ready);
endinterface

`default_nettype wire

/* rtl/dsc_color_if.sv */
// ----------------------------------------------------------------------------
// Color result channel
// Valid/ready channel carrying one shaded color word.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsc_color_if;
  logic                              valid;
  logic                              ready;
  logic [dsc_pkg::COLOR_W-1:0]       red;
  logic [dsc_pkg::COLOR_W-1:0]       green;
  logic [dsc_pkg::COLOR_W-1:0]       blue;
  logic [dsc_pkg::COLOR_W-1:0]       shifted_wavelength;
  logic [dsc_pkg::FACTOR_W-1:0]      doppler_factor;

  modport source(output valid, red, green, blue, shifted_wavelength, doppler_factor,
                 input ready);
  modport sink(input valid, red, green, blue, shifted_wavelength, doppler_factor,
               output ready);
endinterface

`default_nettype wire

/* rtl/dsc_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dsc_pkg::CFG_IDX_W-1:0]     index;
  logic [dsc_pkg::CFG_DATA_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/doppler_shift_color_top.sv */
// ----------------------------------------------------------------------------
// Doppler shift color top level
// Shades one star per word from its velocity with a relativistic Doppler shift.
// ----------------------------------------------------------------------------
// The star channel takes one velocity word (x, y, z in signed Q4.12) and the
// color channel returns one word with red, green, blue, the shifted
// wavelength and the Doppler factor. Both are valid/ready channels.
// The cfg channel writes the observer velocity (index 0) and the observer z
// position (index 1); it is always ready and other indexes are ignored.
// A new word is accepted in every cycle unless the receiver stalls: the
// line-of-sight square root, the two restoring dividers and the factor
// square root resolve one bit per stage. Reset clears all valid bits and
// loads the register defaults (velocity 0, z position 20.0). When the
// receiver stalls, the whole pipeline holds and star ready drops until the
// output word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module doppler_shift_color_top (
  input  wire logic      clk,
  input  wire logic      rst,
  dsc_star_if.sink       star,
  dsc_color_if.source    color,
  dsc_cfg_if.sink        cfg
);

  logic                                   en;
  logic signed [dsc_pkg::OBS_V_W-1:0]     obs_vel;
  logic [dsc_pkg::OBS_Z_W-1:0]            obs_z;

  logic                                   fr_vld;
  logic signed [dsc_pkg::DOT_W-1:0]       fr_dot;
  logic [dsc_pkg::RAD_W-1:0]              fr_rad;

  logic                                   sq_vld;
  logic [dsc_pkg::LEN_W-1:0]              sq_len;
  logic [dsc_pkg::DOT_W-1:0]              sq_dot;

  logic                                   ck_vld;
  logic [dsc_pkg::MAG_W-1:0]              mag_next, ck_mag;
  logic [dsc_pkg::LEN_W-1:0]              ck_len;
  logic [2:0]                             ck_flags;

  logic                                   d1_vld;
  logic [dsc_pkg::BETA_QW-1:0]            d1_quo;
  logic [2:0]                             d1_flags;

  logic signed [13:0]                     beta;
  logic                                   bt_vld;
  logic [12:0]                            bt_num, bt_den;

  logic                                   d2_vld;
  logic [dsc_pkg::RATIO_QW-1:0]           d2_quo;
  logic                                   d2_side;

  logic                                   fs_vld;
  logic [dsc_pkg::FACTOR_W-1:0]           fs_factor;
  logic                                   fs_side;

  assign en        = !color.valid || color.ready;
  assign star.ready = en;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      obs_vel <= dsc_pkg::OBS_VEL_RESET;
      obs_z   <= dsc_pkg::OBS_Z_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        dsc_pkg::REG_OBS_VEL: obs_vel <= cfg.data[dsc_pkg::OBS_V_W-1:0];
        dsc_pkg::REG_OBS_Z:   obs_z   <= cfg.data[dsc_pkg::OBS_Z_W-1:0];
        default: ;
      endcase
    end
  end

  dsc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (star.valid),
    .vx      (star.velocity_x),
    .vy      (star.velocity_y),
    .vz      (star.velocity_z),
    .obs_vel (obs_vel),
    .obs_z   (obs_z),
    .out_vld (fr_vld),
    .dot     (fr_dot),
    .rad     (fr_rad)
  );

  dsc_isqrt #(.W(dsc_pkg::RAD_W), .SW(dsc_pkg::DOT_W)) u_len (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (fr_vld),
    .in_rad   (fr_rad),
    .in_side  (fr_dot),
    .out_vld  (sq_vld),
    .out_root (sq_len),
    .out_side (sq_dot)
  );

  assign mag_next = sq_dot[dsc_pkg::DOT_W-1] ? dsc_pkg::MAG_W'(-sq_dot)
                                             : sq_dot[dsc_pkg::MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ck_vld <= 1'b0;
    end else if (en) begin
      ck_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ck_mag      <= mag_next;
      ck_len      <= sq_len;
      ck_flags[0] <= sq_dot[dsc_pkg::DOT_W-1];
      ck_flags[1] <= mag_next >= dsc_pkg::MAG_W'({sq_len, 12'd0});
      ck_flags[2] <= sq_len == '0;
    end
  end

  dsc_div #(
    .NW(dsc_pkg::MAG_W), .DW(dsc_pkg::LEN_W), .QW(dsc_pkg::BETA_QW), .SW(3)
  ) u_beta_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (ck_vld),
    .in_num   (ck_mag),
    .in_den   (ck_len),
    .in_side  (ck_flags),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_side (d1_flags)
  );

  always_comb begin
    if (d1_flags[2]) begin
      beta = '0;
    end else if (d1_flags[1]) begin
      beta = d1_flags[0] ? -14'(dsc_pkg::BETA_LIMIT) : 14'(dsc_pkg::BETA_LIMIT);
    end else begin
      beta = d1_flags[0] ? -14'(d1_quo) : 14'(d1_quo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bt_vld <= 1'b0;
    end else if (en) begin
      bt_vld <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bt_num <= 13'(14'(dsc_pkg::ONE_Q12) + beta);
      bt_den <= 13'(14'(dsc_pkg::ONE_Q12) - beta);
    end
  end

  dsc_div #(
    .NW(dsc_pkg::RATIO_NW), .DW(13), .QW(dsc_pkg::RATIO_QW), .SW(0)
  ) u_ratio_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (bt_vld),
    .in_num   ({bt_num, 24'd0}),
    .in_den   (bt_den),
    .in_side  (1'b0),
    .out_vld  (d2_vld),
    .out_quo  (d2_quo),
    .out_side (d2_side)
  );

  dsc_isqrt #(.W(dsc_pkg::RATIO_QW), .SW(0)) u_factor (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (d2_vld),
    .in_rad   (d2_quo),
    .in_side  (d2_side),
    .out_vld  (fs_vld),
    .out_root (fs_factor),
    .out_side (fs_side)
  );

  dsc_color u_color (
    .clk        (clk),
    .rst        (rst),
    .en         (en && !fs_side),
    .in_vld     (fs_vld),
    .factor     (fs_factor),
    .out_vld    (color.valid),
    .red        (color.red),
    .green      (color.green),
    .blue       (color.blue),
    .wavelength (color.shifted_wavelength),
    .factor_out (color.doppler_factor)
  );

endmodule

`default_nettype wire

/* rtl/dsc_front.sv */
// ----------------------------------------------------------------------------
// Doppler front end
// Line of sight, dot product and squared length in three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire logic                                  in_vld,
  input  wire logic signed [dsc_pkg::VEL_W-1:0]      vx,
  input  wire logic signed [dsc_pkg::VEL_W-1:0]      vy,
  input  wire logic signed [dsc_pkg::VEL_W-1:0]      vz,
  input  wire logic signed [dsc_pkg::OBS_V_W-1:0]    obs_vel,
  input  wire logic [dsc_pkg::OBS_Z_W-1:0]           obs_z,
  output logic                                       out_vld,
  output logic signed [dsc_pkg::DOT_W-1:0]           dot,
  output logic [dsc_pkg::RAD_W-1:0]                  rad
);

  logic [2:0]         vld;
  logic signed [15:0] vx_a, vy_a;
  logic signed [16:0] dx_a, dy_a, rz_a;
  logic signed [21:0] dz_a;
  logic signed [32:0] pxx, pyy;
  logic signed [38:0] pzz;
  logic signed [33:0] sxx, syy;
  logic signed [43:0] szz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx_a <= vx;
      vy_a <= vy;
      dx_a <= -17'(vx);
      dy_a <= -17'(vy);
      dz_a <= $signed({2'b00, obs_z}) - 22'(vz);
      rz_a <= 17'(vz) - 17'(obs_vel);
      pxx  <= 33'(vx_a) * 33'(dx_a);
      pyy  <= 33'(vy_a) * 33'(dy_a);
      pzz  <= 39'(rz_a) * 39'(dz_a);
      sxx  <= 34'(dx_a) * 34'(dx_a);
      syy  <= 34'(dy_a) * 34'(dy_a);
      szz  <= 44'(dz_a) * 44'(dz_a);
      dot  <= 40'(pxx) + 40'(pyy) + 40'(pzz);
      rad  <= 42'(sxx[33:0]) + 42'(syy[33:0]) + szz[41:0];
    end
  end

  assign out_vld = vld[2];

endmodule

`default_nettype wire

/* rtl/dsc_isqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per stage, with a carried side word.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_isqrt #(
  parameter int W  = 42,
  parameter int SW = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_vld,
  input  wire logic [W-1:0]                  in_rad,
  input  wire logic [(SW>0 ? SW-1 : 0):0]    in_side,
  output logic                               out_vld,
  output logic [W/2-1:0]                     out_root,
  output logic [(SW>0 ? SW-1 : 0):0]         out_side
);

  localparam int S = W / 2;

  logic [S:0]   vld;
  logic [W-1:0] rad_q [0:S];
  logic [W-1:0] res_q [0:S];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_q[0] <= in_rad;
      res_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < S; k++) begin : g_step
    logic [W-1:0] bitv;
    logic [W:0]   trial;
    logic         ge;
    assign bitv  = W'(1) << (W - 2 - 2 * k);
    assign trial = {1'b0, res_q[k]} + {1'b0, bitv};
    assign ge    = {1'b0, rad_q[k]} >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k+1] <= ge ? rad_q[k] - trial[W-1:0] : rad_q[k];
        res_q[k+1] <= ge ? (res_q[k] >> 1) + bitv : res_q[k] >> 1;
      end
    end
  end

  if (SW > 0) begin : g_side
    logic [SW-1:0] side_q [0:S];
    always_ff @(posedge clk) begin
      if (en) begin
        side_q[0] <= in_side;
        for (int i = 0; i < S; i++) begin
          side_q[i+1] <= side_q[i];
        end
      end
    end
    assign out_side = side_q[S];
  end else begin : g_noside
    assign out_side = '0;
  end

  assign out_vld  = vld[S];
  assign out_root = res_q[S][W/2-1:0];

endmodule

`default_nettype wire

/* rtl/dsc_div.sv */
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per stage, with a carried side word.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_div #(
  parameter int NW = 39,
  parameter int DW = 21,
  parameter int QW = 12,
  parameter int SW = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_vld,
  input  wire logic [NW-1:0]                 in_num,
  input  wire logic [DW-1:0]                 in_den,
  input  wire logic [(SW>0 ? SW-1 : 0):0]    in_side,
  output logic                               out_vld,
  output logic [QW-1:0]                      out_quo,
  output logic [(SW>0 ? SW-1 : 0):0]         out_side
);

  localparam int XW = (NW > DW + QW) ? NW : DW + QW;

  logic [QW:0]   vld;
  logic [XW-1:0] rem_q [0:QW];
  logic [DW-1:0] den_q [0:QW];
  logic [QW-1:0] quo_q [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= XW'(in_num);
      den_q[0] <= in_den;
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [XW-1:0] sub;
    logic          ge;
    assign sub = XW'(den_q[k]) << (QW - 1 - k);
    assign ge  = rem_q[k] >= sub;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? rem_q[k] - sub : rem_q[k];
        quo_q[k+1] <= ge ? quo_q[k] | (QW'(1) << (QW - 1 - k)) : quo_q[k];
        den_q[k+1] <= den_q[k];
      end
    end
  end

  if (SW > 0) begin : g_side
    logic [SW-1:0] side_q [0:QW];
    always_ff @(posedge clk) begin
      if (en) begin
        side_q[0] <= in_side;
        for (int i = 0; i < QW; i++) begin
          side_q[i+1] <= side_q[i];
        end
      end
    end
    assign out_side = side_q[QW];
  end else begin : g_noside
    assign out_side = '0;
  end

  assign out_vld = vld[QW];
  assign out_quo = quo_q[QW];

endmodule

`default_nettype wire

/* rtl/dsc_color.sv */
// ----------------------------------------------------------------------------
// Spectrum color mapper
// Wavelength clamp and six-segment piecewise-linear RGB in two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dsc_color (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_vld,
  input  wire logic [dsc_pkg::FACTOR_W-1:0]      factor,
  output logic                                   out_vld,
  output logic [dsc_pkg::COLOR_W-1:0]            red,
  output logic [dsc_pkg::COLOR_W-1:0]            green,
  output logic [dsc_pkg::COLOR_W-1:0]            blue,
  output logic [dsc_pkg::COLOR_W-1:0]            wavelength,
  output logic [dsc_pkg::FACTOR_W-1:0]           factor_out
);

  logic [1:0]          vld;
  logic [12:0]         w_next, w_a;
  logic [16:0]         w20;
  logic [12:0]         r_next, g_next, b_next, r_a, g_a, b_a;
  logic [13:0]         num_next, num_a;
  dsc_pkg::qsel_t      sel_next, sel_a;
  logic [15:0]         f_a;
  logic [29:0]         prod;
  logic [12:0]         quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[0], in_vld};
    end
  end

  always_comb begin
    w_next   = (factor[15:1] > 15'(dsc_pkg::ONE_Q12)) ? 13'(dsc_pkg::ONE_Q12)
                                                      : factor[13:1];
    w20      = 17'(w_next) * 17'd20;
    r_next   = '0;
    g_next   = '0;
    b_next   = '0;
    num_next = '0;
    sel_next = dsc_pkg::QSEL_NONE;
    if (w_next <= 13'(dsc_pkg::SEG_VIOLET)) begin
      r_next = 13'({w_next, 1'b0});
      b_next = 13'(14'd2048 + {w_next, 1'b0});
    end else if (w_next <= 13'(dsc_pkg::SEG_BLUE)) begin
      b_next   = 13'(dsc_pkg::ONE_Q12);
      num_next = 14'(w20 - 17'd20480);
      sel_next = dsc_pkg::QSEL_GREEN;
    end else if (w_next <= 13'(dsc_pkg::SEG_CYAN)) begin
      g_next   = 13'(dsc_pkg::ONE_Q12);
      num_next = 14'(17'd45056 - w20);
      sel_next = dsc_pkg::QSEL_BLUE;
    end else if (w_next <= 13'(dsc_pkg::SEG_GREEN)) begin
      r_next = 13'(w20 - 17'd45056);
      g_next = 13'(dsc_pkg::ONE_Q12);
    end else if (w_next <= 13'(dsc_pkg::SEG_YELLOW)) begin
      r_next   = 13'(dsc_pkg::ONE_Q12);
      num_next = 14'(17'd61440 - w20);
      sel_next = dsc_pkg::QSEL_GREEN;
    end else begin
      r_next = 13'(dsc_pkg::ONE_Q12);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_a   <= w_next;
      r_a   <= r_next;
      g_a   <= g_next;
      b_a   <= b_next;
      num_a <= num_next;
      sel_a <= sel_next;
      f_a   <= factor;
    end
  end

  assign prod = 30'(num_a) * 30'(dsc_pkg::RECIP3);
  assign quo  = prod[dsc_pkg::RECIP3_SHFT +: 13];

  always_ff @(posedge clk) begin
    if (en) begin
      red        <= r_a;
      wavelength <= w_a;
      factor_out <= f_a;
      case (sel_a)
        dsc_pkg::QSEL_GREEN: begin
          green <= quo;
          blue  <= b_a;
        end
        dsc_pkg::QSEL_BLUE: begin
          green <= g_a;
          blue  <= quo;
        end
        default: begin
          green <= g_a;
          blue  <= b_a;
        end
      endcase
    end
  end

  assign out_vld = vld[1];

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Doppler shift color testbench
// Drives star velocity words through the shading pipeline with random bursts,
// stalls and observer settings, and checks every color word against an
// in-bench fixed-point prediction of the Doppler factor and spectrum.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dsc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [dsc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] vz;
  } star_t;

  typedef struct packed {
    logic [12:0] red;
    logic [12:0] green;
    logic [12:0] blue;
    logic [12:0] wave;
    logic [15:0] factor;
  } shade_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  dsc_star_if  star();
  dsc_color_if color();
  dsc_cfg_if   cfg();

  doppler_shift_color_top dut (
    .clk(clk), .rst(rst), .star(star.sink), .color(color.source), .cfg(cfg.sink)
  );

  logic signed [63:0] obs_vel = 0;
  logic signed [63:0] obs_z = 81920;

  star_t  pending_stars[$];
  shade_t expected_shades[$];
  int     errors = 0;
  int     accepted = 0;
  int     checked = 0;
  int     cycles = 0;
  int     burst_left = 0;
  int     gap_left = 0;
  int     hold_off = 0;
  bit     hold_req = 1'b0;
  bit     drain_req = 1'b0;

  function automatic logic [63:0] root_floor(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic shade_t shade_star(star_t s);
    logic signed [63:0] vx, vy, vz, dx, dy, dz, rz, dotp, len, beta;
    logic [63:0] num, den, fac, w, r, g, b;
    shade_t o;
    vx = $signed(s.vx);
    vy = $signed(s.vy);
    vz = $signed(s.vz);
    dx = -vx;
    dy = -vy;
    dz = obs_z - vz;
    rz = vz - obs_vel;
    dotp = vx * dx + vy * dy + rz * dz;
    len = $signed(root_floor(dx * dx + dy * dy + dz * dz));
    beta = 0;
    if (len != 0) beta = dotp / len;
    if (beta >= dsc_pkg::ONE_Q12) beta = dsc_pkg::BETA_LIMIT;
    if (beta <= -dsc_pkg::ONE_Q12) beta = -dsc_pkg::BETA_LIMIT;
    num = dsc_pkg::ONE_Q12 + beta;
    den = dsc_pkg::ONE_Q12 - beta;
    fac = root_floor((num << 24) / den);
    if (fac > 65535) fac = 65535;
    w = fac >> 1;
    if (w > dsc_pkg::ONE_Q12) w = dsc_pkg::ONE_Q12;
    if (w <= dsc_pkg::SEG_VIOLET) begin
      r = 2 * w; g = 0; b = 2048 + 2 * w;
    end else if (w <= dsc_pkg::SEG_BLUE) begin
      r = 0; g = (20 * w - 20480) / 3; b = dsc_pkg::ONE_Q12;
    end else if (w <= dsc_pkg::SEG_CYAN) begin
      r = 0; g = dsc_pkg::ONE_Q12; b = (45056 - 20 * w) / 3;
    end else if (w <= dsc_pkg::SEG_GREEN) begin
      r = 20 * w - 45056; g = dsc_pkg::ONE_Q12; b = 0;
    end else if (w <= dsc_pkg::SEG_YELLOW) begin
      r = dsc_pkg::ONE_Q12; g = (61440 - 20 * w) / 3; b = 0;
    end else begin
      r = dsc_pkg::ONE_Q12; g = 0; b = 0;
    end
    o.red = r[12:0];
    o.green = g[12:0];
    o.blue = b[12:0];
    o.wave = w[12:0];
    o.factor = fac[15:0];
    return o;
  endfunction

  // Driver: bursts of words with random gaps, paused on request.
  always @(posedge clk) begin
    if (rst) begin
      star.valid <= 1'b0;
    end else if (!star.valid || star.ready) begin
      if (star.valid) begin
        expected_shades.insert(expected_shades.size(),
                               shade_star({star.velocity_x, star.velocity_y,
                                           star.velocity_z}));
        accepted <= accepted + 1;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        star.valid <= 1'b0;
      end else if (pending_stars.size() == 0 || drain_req) begin
        star.valid <= 1'b0;
      end else begin
        star_t s;
        s = pending_stars.pop_front();
        star.valid <= 1'b1;
        star.velocity_x <= s.vx;
        star.velocity_y <= s.vy;
        star.velocity_z <= s.vz;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Receiver stall pattern, plus long hold-offs on request.
  always @(posedge clk) begin
    if (rst) begin
      color.ready <= 1'b0;
      hold_off <= 0;
    end else if (hold_req && hold_off == 0) begin
      hold_off <= 300;
      color.ready <= 1'b0;
    end else if (hold_off > 1) begin
      hold_off <= hold_off - 1;
      color.ready <= 1'b0;
    end else begin
      hold_off <= 0;
      case ((cycles >> 9) % 3)
        0: color.ready <= 1'b1;
        1: color.ready <= ($urandom_range(0, 3) != 0);
        default: color.ready <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Monitor.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && color.valid && color.ready) begin
      shade_t got, want;
      got = {color.red, color.green, color.blue, color.shifted_wavelength,
             color.doppler_factor};
      if (expected_shades.size() == 0) begin
        $display("%0t: unexpected color word %h", $time, got);
        errors++;
      end else begin
        want = expected_shades.pop_front();
        checked++;
        if (got.red != want.red) begin
          $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
          errors++;
        end
        if (got.green != want.green) begin
          $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
          errors++;
        end
        if (got.blue != want.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
          errors++;
        end
        if (got.wave != want.wave) begin
          $display("%0t: wavelength expected %0d actual %0d", $time, want.wave,
                   got.wave);
          errors++;
        end
        if (got.factor != want.factor) begin
          $display("%0t: factor expected %0d actual %0d", $time, want.factor,
                   got.factor);
          errors++;
        end
      end
    end
    if (cycles > 2000000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_stars.size() != 0 || star.valid || expected_shades.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [dsc_pkg::CFG_IDX_W-1:0] idx,
                           logic [dsc_pkg::CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == dsc_pkg::REG_OBS_VEL) obs_vel = $signed(val[12:0]);
    else if (idx == dsc_pkg::REG_OBS_Z) obs_z = val;
  endtask

  task automatic add_star(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    star_t s;
    s.vx = x;
    s.vy = y;
    s.vz = z;
    pending_stars.insert(pending_stars.size(), s);
  endtask

  function automatic logic [15:0] rand_vel();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 8191) - 4096);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  logic [19:0] vel_set[6] = '{20'h0, 20'd3687, 20'h1f199, 20'h00fff, 20'h01000, 20'h0};
  logic [19:0] z_set[6] = '{20'd81920, 20'd0, 20'hfffff, 20'd4096, 20'd40000, 20'd81920};

  initial begin
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, zero line of sight, approaching and receding stars.
    add_star(16'h0000, 16'h0000, 16'h0000);
    add_star(16'h7fff, 16'h7fff, 16'h7fff);
    add_star(16'h8000, 16'h8000, 16'h8000);
    add_star(16'h7fff, 16'h8000, 16'h0000);
    add_star(16'h0000, 16'h0000, 16'h7fff);
    add_star(16'h0000, 16'h0000, 16'h8000);
    add_star(16'h0000, 16'h0000, 16'h0800);
    add_star(16'h0000, 16'h0000, 16'hf800);
    add_star(16'h1000, 16'h0000, 16'h0000);
    add_star(16'hffff, 16'h0001, 16'hffff);
    add_star(16'h5555, 16'haaaa, 16'h5555);
    for (int i = -8; i <= 8; i++) add_star(16'h0000, 16'h0000, 16'(i * 200));
    wait_idle();
    write_reg(dsc_pkg::REG_OBS_Z, 20'd4096);
    repeat (2) @(posedge clk);
    add_star(16'h0000, 16'h0000, 16'h1000);
    add_star(16'h0000, 16'h0000, 16'h1001);
    wait_idle();
    write_reg(REG_SPARE_LO, 20'd7);
    write_reg(REG_SPARE_HI, 20'd9);
    add_star(16'h0000, 16'h0000, 16'h1000);
    add_star(16'h0100, 16'h0000, 16'h0800);
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      write_reg(dsc_pkg::REG_OBS_VEL, vel_set[phase]);
      write_reg(dsc_pkg::REG_OBS_Z, z_set[phase]);
      for (int i = 0; i < 230; i++) begin
        if ($urandom_range(0, 9) == 0)
          add_star(16'h0000, 16'h0000, z_set[phase][15:0]);
        else
          add_star(rand_vel(), rand_vel(), rand_vel());
      end
      if (phase == 2) begin
        repeat (20) @(posedge clk);
        hold_req = 1'b1;
        while (hold_off == 0) @(posedge clk);
        hold_req = 1'b0;
      end
      if (phase == 4) begin
        repeat (200) @(posedge clk);
        drain_req = 1'b1;
        while (star.valid || expected_shades.size() != 0) @(posedge clk);
        drain_req = 1'b0;
      end
      wait_idle();
    end

    $display("Shaded %0d star words over six observer settings, %0d checked.",
             accepted, checked);
    if (errors == 0 && expected_shades.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* filelist.f */
rtl/dsc_pkg.sv
rtl/dsc_star_if.sv
rtl/dsc_color_if.sv
rtl/dsc_cfg_if.sv
rtl/dsc_front.sv
rtl/dsc_isqrt.sv
rtl/dsc_div.sv
rtl/dsc_color.sv
rtl/doppler_shift_color_top.sv
tb/tb_top.sv
